[design/i2of5_pkg.sv]
// i2of5_pkg: shared types, constants and helper functions for the
// interleaved 2 of 5 bar width encoder. No dependencies.
package i2of5_pkg;

  // largest pair count the sizing logic accepts
  localparam int MaxPairs = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_DESIRED_WIDTH = 2'd0;
  localparam logic [1:0] CFG_PAIR_COUNT    = 2'd1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DIGIT  = 2'd1,
    ST_TOO_SMALL  = 2'd2,
    ST_ZERO_WIDTH = 2'd3
  } status_t;

  // command passed from the front to the back through the queue
  typedef struct packed {
    status_t     status;
    logic        start;    // send the four start elements first
    logic        last;     // send the stop elements after the pair
    logic [9:0]  pattern;  // interleaved wide marks, first element in bit 9
    logic [15:0] narrow_px;
    logic [15:0] wide_px;
    logic [15:0] total_px;
  } cmd_t;

  // front sequencer states
  typedef enum logic [2:0] {
    F_IDLE,
    F_EVAL,
    F_DIV12,
    F_MUL12,
    F_DIV25,
    F_MUL25,
    F_PUSH
  } fstate_t;

  // bar pattern of one digit, wide bars at the odd bits
  function automatic logic [9:0] bar_code(input logic [3:0] d);
    logic [9:0] r;
    case (d)
      4'd0:    r = 10'h028;
      4'd1:    r = 10'h202;
      4'd2:    r = 10'h082;
      4'd3:    r = 10'h280;
      4'd4:    r = 10'h022;
      4'd5:    r = 10'h220;
      4'd6:    r = 10'h0a0;
      4'd7:    r = 10'h00a;
      4'd8:    r = 10'h208;
      4'd9:    r = 10'h088;
      default: r = 10'h000;
    endcase
    return r;
  endfunction

  // true when the character is not an ascii digit
  function automatic logic digit_bad(input logic [7:0] c);
    return (c < 8'h30) || (c > 8'h39);
  endfunction

  // bars from the first digit, spaces from the second
  function automatic logic [9:0] pair_pattern(input logic [7:0] c1, input logic [7:0] c2);
    logic [9:0] b;
    logic [9:0] s;
    b = bar_code(c1[3:0]);
    s = bar_code(c2[3:0]);
    return b | (s >> 1);
  endfunction

  // pair count limited to 1..MaxPairs
  function automatic logic [5:0] pairs_clamped(input logic [5:0] p);
    logic [5:0] r;
    r = p;
    if (p == 6'd0) r = 6'd1;
    if (p > 6'(MaxPairs)) r = 6'(MaxPairs);
    return r;
  endfunction

  // minimum width with a 1:2 ratio: 14 * pairs + 8
  function automatic logic [8:0] min_width12(input logic [5:0] p);
    return {p, 3'b000} + {1'b0, p, 2'b00} + {2'b00, p, 1'b0} + 9'd8;
  endfunction

  // minimum width with a 2:5 ratio: 32 * pairs + 17
  function automatic logic [10:0] min_width25(input logic [5:0] p);
    return {p, 5'b00000} + 11'd17;
  endfunction

endpackage

[design/i2of5_bar_width_encoder_unit.sv]
// i2of5_bar_width_encoder_unit: top level of the interleaved 2 of 5 bar
// width encoder. Uses i2of5_pkg, i2of5_front, i2of5_queue, i2of5_back.
//
// Usage: each input word carries one digit pair (bars digit, spaces digit)
// with tlast on the final pair of a message. Each output word is one bar or
// space: its width in pixels, wide and bar flags, and the message total.
// tuser gives the status; tlast marks the last word of a message or an
// error word. An error gives one word, then words are dropped up to the
// next pair marked last. Write desired_width and pair_count only while idle.
// Throughput is set by the back end, one element word per cycle while
// the receiver accepts and commands are queued: 10 words per pair, 4
// more on the first pair and 3 more on the last one. The front sizes
// a message on its first pair, where one bit-serial divider runs for the
// 1:2 ratio and again for 2:5 when that ratio fits. A two-entry command
// queue lets the front take the next pair while the back still sends. A
// stalled receiver holds the output register; the queue then fills and
// the input stops. Reset (rst, synchronous) clears the message state and
// the queue and sets desired_width to 0 and pair_count to 1.
module i2of5_bar_width_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // first_char[7:0], second_char[15:8]
  input  logic        s_tlast,   // last_pair
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // element_px[15:0], is_wide[16], is_bar[17], total_px[33:18]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast,   // end_of_run
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  i2of5_pkg::cmd_t q_in;
  i2of5_pkg::cmd_t q_head;

  i2of5_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  i2of5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  i2of5_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[design/i2of5_div.sv]
// i2of5_div: restoring divider, one quotient bit per cycle, for the
// message sizing. Depends on nothing.
module i2of5_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        busy;
  logic [3:0]  cnt;
  logic [10:0] rem;
  logic [10:0] dvs;
  logic [15:0] quo;
  logic [11:0] trial;
  logic        ge;
  logic [11:0] diff;

  // one trial subtract per cycle
  always_comb begin
    trial = {rem, quo[15]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= 4'd15;
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt - 4'd1;
      rem <= ge ? diff[10:0] : trial[10:0];
      quo <= {quo[14:0], ge};
    end
  end

  assign quotient = quo;

endmodule

[design/i2of5_front.sv]
// i2of5_front: accepts digit pairs, holds the configuration registers,
// sizes each message and queues commands. Uses i2of5_pkg and i2of5_div.
module i2of5_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,
  input  logic              s_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output i2of5_pkg::cmd_t   q_cmd
);

  i2of5_pkg::fstate_t state, state_next;

  logic [15:0] desired_width;
  logic [5:0]  pair_count;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic        last_pair;
  logic        started;
  logic        dropping;
  logic [15:0] narrow_px;
  logic [15:0] wide_px;
  logic [15:0] total_width;
  logic [15:0] quo12;
  logic [15:0] quo25;
  logic [15:0] t12;
  logic [15:0] t25;
  logic        have25;

  logic [5:0]  p_eff;
  logic [8:0]  min12;
  logic [10:0] min25;
  logic        pair_bad;
  logic        fits25;
  logic        use25;
  logic [15:0] prod12;
  logic [15:0] prod25;
  logic        eval_err;
  i2of5_pkg::status_t eval_status;

  logic        div_start;
  logic [10:0] div_divisor;
  logic        div_done;
  logic [15:0] div_q;

  i2of5_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (desired_width),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // sizing terms and item classification
  always_comb begin
    p_eff    = i2of5_pkg::pairs_clamped(pair_count);
    min12    = i2of5_pkg::min_width12(p_eff);
    min25    = i2of5_pkg::min_width25(p_eff);
    pair_bad = i2of5_pkg::digit_bad(first_char) || i2of5_pkg::digit_bad(second_char);
    fits25   = {5'b0, min25} <= desired_width;
    use25    = have25 && (t25 >= t12);
    // quotient times divisor never exceeds the 16-bit dividend
    prod12   = quo12 * {7'b0, min12};
    prod25   = quo25 * {5'b0, min25};
    eval_err    = 1'b0;
    eval_status = i2of5_pkg::ST_OK;
    if (!started) begin
      if (desired_width == 16'd0) begin
        eval_err    = 1'b1;
        eval_status = i2of5_pkg::ST_ZERO_WIDTH;
      end else if (desired_width < {7'b0, min12}) begin
        eval_err    = 1'b1;
        eval_status = i2of5_pkg::ST_TOO_SMALL;
      end else if (pair_bad) begin
        eval_err    = 1'b1;
        eval_status = i2of5_pkg::ST_BAD_DIGIT;
      end
    end else if (pair_bad) begin
      eval_err    = 1'b1;
      eval_status = i2of5_pkg::ST_BAD_DIGIT;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      i2of5_pkg::F_IDLE: begin
        if (s_tvalid) state_next = i2of5_pkg::F_EVAL;
      end
      i2of5_pkg::F_EVAL: begin
        if (dropping) state_next = i2of5_pkg::F_IDLE;
        else if (!started && !eval_err) state_next = i2of5_pkg::F_DIV12;
        else if (!q_full) state_next = i2of5_pkg::F_IDLE;
      end
      i2of5_pkg::F_DIV12: begin
        if (div_done) state_next = i2of5_pkg::F_MUL12;
      end
      i2of5_pkg::F_MUL12: begin
        state_next = fits25 ? i2of5_pkg::F_DIV25 : i2of5_pkg::F_PUSH;
      end
      i2of5_pkg::F_DIV25: begin
        if (div_done) state_next = i2of5_pkg::F_MUL25;
      end
      i2of5_pkg::F_MUL25: state_next = i2of5_pkg::F_PUSH;
      i2of5_pkg::F_PUSH: begin
        if (!q_full) state_next = i2of5_pkg::F_IDLE;
      end
      default: state_next = i2of5_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready         = state == i2of5_pkg::F_IDLE;
    q_push           = 1'b0;
    div_start        = 1'b0;
    div_divisor      = {2'b0, min12};
    q_cmd.status     = eval_status;
    q_cmd.start      = 1'b0;
    q_cmd.last       = last_pair;
    q_cmd.pattern    = i2of5_pkg::pair_pattern(first_char, second_char);
    q_cmd.narrow_px  = narrow_px;
    q_cmd.wide_px    = wide_px;
    q_cmd.total_px   = total_width;
    case (state)
      i2of5_pkg::F_EVAL: begin
        if (!dropping) begin
          if (!started && !eval_err) div_start = 1'b1;
          else q_push = !q_full;
        end
      end
      i2of5_pkg::F_MUL12: begin
        div_start   = fits25;
        div_divisor = min25;
      end
      i2of5_pkg::F_PUSH: begin
        q_push       = !q_full;
        q_cmd.status = i2of5_pkg::ST_OK;
        q_cmd.start  = 1'b1;
        if (use25) begin
          q_cmd.narrow_px = {quo25[14:0], 1'b0};
          q_cmd.wide_px   = quo25 + {quo25[13:0], 2'b00};
          q_cmd.total_px  = t25;
        end else begin
          q_cmd.narrow_px = quo12;
          q_cmd.wide_px   = {quo12[14:0], 1'b0};
          q_cmd.total_px  = t12;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= i2of5_pkg::F_IDLE;
      desired_width <= '0;
      pair_count    <= 6'd1;
      started       <= 1'b0;
      dropping      <= 1'b0;
      narrow_px     <= '0;
      wide_px       <= '0;
      total_width   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          i2of5_pkg::CFG_DESIRED_WIDTH: desired_width <= cfg_data;
          i2of5_pkg::CFG_PAIR_COUNT:    pair_count    <= cfg_data[5:0];
          default: ;
        endcase
      end
      // message tracking at evaluation
      if (state == i2of5_pkg::F_EVAL) begin
        if (dropping) begin
          if (last_pair) dropping <= 1'b0;
        end else if (q_push) begin
          if (eval_err) begin
            started  <= 1'b0;
            dropping <= !last_pair;
          end else begin
            started <= !last_pair;
          end
        end
      end
      // sizing result of the first pair
      if (state == i2of5_pkg::F_PUSH && q_push) begin
        started     <= !last_pair;
        narrow_px   <= q_cmd.narrow_px;
        wide_px     <= q_cmd.wide_px;
        total_width <= q_cmd.total_px;
      end
    end
  end

  // item and sizing datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      first_char  <= s_tdata[7:0];
      second_char <= s_tdata[15:8];
      last_pair   <= s_tlast;
    end
    if (state == i2of5_pkg::F_DIV12 && div_done) quo12 <= div_q;
    if (state == i2of5_pkg::F_DIV25 && div_done) quo25 <= div_q;
    if (state == i2of5_pkg::F_MUL12) begin
      t12    <= prod12;
      have25 <= fits25;
    end
    if (state == i2of5_pkg::F_MUL25) t25 <= prod25;
  end

endmodule

[design/i2of5_queue.sv]
// i2of5_queue: two-entry command queue between front and back.
// Uses i2of5_pkg for the command type.
module i2of5_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2of5_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output i2of5_pkg::cmd_t head_cmd
);

  i2of5_pkg::cmd_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_cmd   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

endmodule

[design/i2of5_back.sv]
// i2of5_back: walks each queued command and sends one element word per
// cycle while the receiver accepts, through an output register. Uses i2of5_pkg.
module i2of5_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  i2of5_pkg::cmd_t head_cmd,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  // element positions: start 0..3, pair 4..13, stop 14..16
  localparam logic [4:0] PosPair  = 5'd4;
  localparam logic [4:0] PosPairEnd = 5'd13;
  localparam logic [4:0] PosStopWide = 5'd14;
  localparam logic [4:0] PosEnd   = 5'd16;

  logic        busy;
  logic [4:0]  pos;
  logic [4:0]  pos_cur;
  logic [4:0]  pos_end;
  logic [4:0]  off;
  logic        is_err;
  logic        load;
  logic        wide;
  logic        fin;

  // current element
  always_comb begin
    pos_cur = busy ? pos : (head_cmd.start ? 5'd0 : PosPair);
    pos_end = head_cmd.last ? PosEnd : PosPairEnd;
    off     = PosPairEnd - pos_cur;
    is_err  = head_cmd.status != i2of5_pkg::ST_OK;
    if (pos_cur < PosPair) wide = 1'b0;
    else if (pos_cur <= PosPairEnd) wide = head_cmd.pattern[off[3:0]];
    else wide = pos_cur == PosStopWide;
    load = head_valid && (!m_tvalid || m_tready);
    fin  = is_err || pos_cur == pos_end;
    pop  = load && fin;
  end

  // position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy     <= !fin;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      pos <= pos_cur + 5'd1;
      if (is_err) begin
        m_tdata <= '0;
        m_tuser <= head_cmd.status;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {6'b0, head_cmd.total_px, !pos_cur[0], wide,
                    wide ? head_cmd.wide_px : head_cmd.narrow_px};
        m_tuser <= i2of5_pkg::ST_OK;
        m_tlast <= pos_cur == PosEnd;
      end
    end
  end

endmodule

[verif/i2of5_bar_width_encoder_unit_tb.sv]
// i2of5_bar_width_encoder_unit_tb: self-checking bench for the interleaved 2 of 5
// bar width encoder. Predicts every element word from its own copy of the sizing
// and pattern logic. Depends on i2of5_pkg and i2of5_bar_width_encoder_unit.
module i2of5_bar_width_encoder_unit_tb;
  import i2of5_pkg::*;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  // register indexes with no register behind them
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PAIRS = 435;

  // one predicted bar or space word
  typedef struct {
    logic [15:0] element_px;
    logic        is_wide;
    logic        is_bar;
    logic [15:0] total_px;
    status_t     status;
    logic        end_of_run;
  } bar_word_t;

  class bar_width_scoreboard;
    logic [15:0] desired_width;
    logic [5:0]  pair_count;
    bit          in_message;
    bit          skipping;
    logic [15:0] narrow_w;
    logic [15:0] wide_w;
    logic [15:0] total_w;
    logic [9:0]  bar_tab[10];
    bar_word_t   owed_words[$];
    int          errors;
    int          n_pairs;
    int          n_used;
    int          n_words;
    int          n_settings;

    function new();
      desired_width = 16'd0;
      pair_count = 6'd1;
      in_message = 1'b0;
      skipping = 1'b0;
      narrow_w = 16'd0;
      wide_w = 16'd0;
      total_w = 16'd0;
      bar_tab = '{10'h028, 10'h202, 10'h082, 10'h280, 10'h022,
                  10'h220, 10'h0a0, 10'h00a, 10'h208, 10'h088};
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_DESIRED_WIDTH) desired_width = val;
      else if (idx == CFG_PAIR_COUNT) pair_count = val[5:0];
    endfunction

    function bit non_digit(logic [7:0] c);
      return (c < CHAR_ZERO) || (c > CHAR_NINE);
    endfunction

    function void push(logic [15:0] px, logic wide, logic bar, logic [15:0] tot,
                       status_t st, logic eor);
      bar_word_t w;
      w.element_px = px;
      w.is_wide = wide;
      w.is_bar = bar;
      w.total_px = tot;
      w.status = st;
      w.end_of_run = eor;
      owed_words.push_back(w);
    endfunction

    function void element(logic wide, logic bar, logic eor);
      push(wide ? wide_w : narrow_w, wide, bar, total_w, ST_OK, eor);
    endfunction

    // error word, then skip to the end of the message unless this was it
    function void fault(status_t st, bit last);
      push(16'd0, 1'b0, 1'b0, 16'd0, st, 1'b1);
      in_message = 1'b0;
      skipping = !last;
    endfunction

    function void note_pair(logic [7:0] c1, logic [7:0] c2, bit last);
      int unsigned p, d, n_narrow, n_wide, min12, min25, m, m5, t12, t25, i;
      logic [3:0] d1, d2;
      logic [9:0] pat;
      bit bad;
      n_pairs++;
      bad = non_digit(c1) || non_digit(c2);
      if (skipping) begin
        if (last) skipping = 1'b0;
        return;
      end
      n_used++;
      // size the whole message on its first pair
      if (!in_message) begin
        p = pair_count;
        if (p < 1) p = 1;
        if (p > MaxPairs) p = MaxPairs;
        d = desired_width;
        if (d == 0) begin
          fault(ST_ZERO_WIDTH, last);
          return;
        end
        n_narrow = 6 + 6 * p;
        n_wide = 1 + 4 * p;
        min12 = 2 * n_wide + n_narrow;
        if (d < min12) begin
          fault(ST_TOO_SMALL, last);
          return;
        end
        if (bad) begin
          fault(ST_BAD_DIGIT, last);
          return;
        end
        m = d / min12;
        t12 = m * min12;
        narrow_w = m[15:0];
        wide_w = 16'(2 * m);
        total_w = t12[15:0];
        min25 = 2 * n_narrow + 5 * n_wide;
        if (min25 <= d) begin
          m5 = d / min25;
          t25 = m5 * min25;
          // 2:5 wins a tie
          if (t25 >= t12) begin
            narrow_w = 16'(2 * m5);
            wide_w = 16'(5 * m5);
            total_w = t25[15:0];
          end
        end
        in_message = 1'b1;
        for (i = 0; i < 4; i++) element(1'b0, (i % 2) == 0, 1'b0);
      end else if (bad) begin
        fault(ST_BAD_DIGIT, last);
        return;
      end
      // bars from the first digit, spaces from the second
      d1 = 4'(c1 - CHAR_ZERO);
      d2 = 4'(c2 - CHAR_ZERO);
      pat = bar_tab[d1] | (bar_tab[d2] >> 1);
      for (i = 0; i < 10; i++) element(pat[9 - i], (i % 2) == 0, 1'b0);
      // stop pattern: wide bar, narrow space, narrow bar
      if (last) begin
        element(1'b1, 1'b1, 1'b0);
        element(1'b0, 1'b0, 1'b0);
        element(1'b0, 1'b1, 1'b1);
        in_message = 1'b0;
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [39:0] data, logic [1:0] user, logic last);
      bar_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected word: data %h user %0d last %b", data, user, last);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      n_words++;
      compare("element_px", w.element_px, data[15:0]);
      compare("is_wide", 16'(w.is_wide), 16'(data[16]));
      compare("is_bar", 16'(w.is_bar), 16'(data[17]));
      compare("total_px", w.total_px, data[33:18]);
      compare("status", 16'(w.status), 16'(user));
      compare("end_of_run", 16'(w.end_of_run), 16'(last));
    endfunction

    function void leftover_check();
      if (owed_words.size() != 0) begin
        $error("%0d predicted words never arrived", owed_words.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int send_idle_pct = 21;
  int recv_idle_pct = 79;
  bit hold_req = 1'b0;
  bar_width_scoreboard sb = new();

  i2of5_bar_width_encoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pair(s_tdata[7:0], s_tdata[15:8], s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  // receiver: random backpressure, or a long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] digit_char(int n);
    return CHAR_ZERO + 8'(n);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    case ($urandom_range(7))
      0: c = 8'h00;
      1: c = 8'hff;
      2: c = CHAR_ZERO - 8'd1;
      3: c = CHAR_NINE + 8'd1;
      default: c = 8'($urandom_range(255));
    endcase
    while (c >= CHAR_ZERO && c <= CHAR_NINE) c = 8'($urandom_range(255));
    return c;
  endfunction

  // offer one pair word, keep tvalid high if the next follows at once
  task automatic send_pair(logic [7:0] c1, logic [7:0] c2, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c2, c1};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // n pairs with random digits, last on the final one, optional bad pair
  task automatic send_msg(int n, int bad_at);
    logic [7:0] a, b;
    int i;
    for (i = 0; i < n; i++) begin
      a = digit_char($urandom_range(9));
      b = digit_char($urandom_range(9));
      if (i == bad_at) begin
        case ($urandom_range(2))
          0: a = junk_char();
          1: b = junk_char();
          default: begin
            a = junk_char();
            b = junk_char();
          end
        endcase
      end
      send_pair(a, b, i == n - 1);
    end
  endtask

  // stop offering, wait for every owed word, then let the front settle
  task automatic idle_until_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] width, logic [15:0] pairs_word, bit stray);
    logic [1:0]  idx;
    logic [15:0] junk;
    cfg_we <= 1'b1;
    cfg_index <= CFG_DESIRED_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    sb.set_reg(CFG_DESIRED_WIDTH, width);
    cfg_index <= CFG_PAIR_COUNT;
    cfg_data <= pairs_word;
    @(posedge clk);
    sb.set_reg(CFG_PAIR_COUNT, pairs_word);
    // a write to an index with no register must change nothing
    if (stray) begin
      idx = $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B;
      junk = 16'($urandom);
      cfg_index <= idx;
      cfg_data <= junk;
      @(posedge clk);
      sb.set_reg(idx, junk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.n_settings++;
  endtask

  // one register setting followed by a few messages
  task automatic random_group();
    int pc, p_eff, min12, dw, n, bad_at, nmsg;
    case ($urandom_range(9))
      0: pc = 0;
      1: pc = $urandom_range(33, 63);
      2: pc = $urandom_range(5, 32);
      default: pc = $urandom_range(1, 4);
    endcase
    p_eff = (pc == 0) ? 1 : (pc > MaxPairs ? MaxPairs : pc);
    min12 = 14 * p_eff + 8;
    case ($urandom_range(19))
      0: dw = 0;
      1: dw = $urandom_range(1, min12 - 1);
      2: dw = 65535;
      3: dw = min12;
      4, 5: dw = $urandom_range(min12, 65535);
      default: dw = $urandom_range(min12, 3000);
    endcase
    write_regs(16'(dw), {10'($urandom), 6'(pc)}, $urandom_range(3) == 0);
    nmsg = $urandom_range(1, 3);
    repeat (nmsg) begin
      n = p_eff;
      if ($urandom_range(9) == 0) n = $urandom_range(1, p_eff + 2);
      bad_at = ($urandom_range(9) == 0) ? $urandom_range(0, n - 1) : -1;
      send_msg(n, bad_at);
    end
    idle_until_drained();
  endtask

  initial begin
    int phase, base;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 16'd0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DESIRED_WIDTH;
    cfg_data = 16'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setting: zero width, also with a message that must be skipped
    send_pair(digit_char(1), digit_char(2), 1'b1);
    send_pair(digit_char(3), digit_char(4), 1'b0);
    send_pair(digit_char(5), digit_char(6), 1'b1);
    idle_until_drained();
    // one pixel short of the narrowest 1:2 code
    write_regs(16'd21, 16'd1, 1'b0);
    send_pair(digit_char(7), digit_char(8), 1'b1);
    idle_until_drained();
    // exact 1:2 fit, pair count zero taken as one, bad digits on a first pair
    write_regs(16'd22, 16'd0, 1'b1);
    send_pair(digit_char(0), digit_char(9), 1'b1);
    send_pair(CHAR_ZERO - 8'd1, digit_char(5), 1'b1);
    send_pair(digit_char(5), CHAR_NINE + 8'd1, 1'b1);
    idle_until_drained();
    // both ratios give the same total
    write_regs(16'd1078, 16'd1, 1'b0);
    send_pair(digit_char(4), digit_char(4), 1'b1);
    idle_until_drained();
    // full width, junk above the pair count bits
    write_regs(16'hffff, 16'hffc2, 1'b0);
    send_pair(digit_char(9), digit_char(0), 1'b0);
    send_pair(digit_char(2), digit_char(6), 1'b1);
    // bad digit after elements already sent, rest of message skipped
    send_pair(digit_char(1), digit_char(3), 1'b0);
    send_pair(8'hff, 8'h00, 1'b0);
    send_pair(digit_char(8), digit_char(7), 1'b1);
    // shorter message than sized for
    send_pair(digit_char(6), digit_char(5), 1'b1);
    idle_until_drained();
    // pair count above the maximum, message longer than one pair
    write_regs(16'd9999, 16'd40, 1'b1);
    send_msg(3, -1);
    idle_until_drained();
    write_regs(16'd500, 16'd63, 1'b0);
    send_pair(digit_char(3), digit_char(1), 1'b1);
    idle_until_drained();
    write_regs(16'd455, 16'd32, 1'b0);
    send_pair(digit_char(1), digit_char(1), 1'b1);
    idle_until_drained();

    // random part in three idling phases
    base = sb.n_pairs;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 21 : 0;
      if (phase == 2) begin
        // long receiver hold while a full message keeps coming
        hold_req = 1'b1;
        write_regs(16'd3000, 16'd6, 1'b0);
        send_msg(6, -1);
        idle_until_drained();
      end
      while (sb.n_pairs < base + RANDOM_PAIRS * (phase + 1) / 3) random_group();
    end

    idle_until_drained();
    sb.leftover_check();
    $display("covered %0d pair words (%0d not skipped) over %0d register settings",
             sb.n_pairs, sb.n_used, sb.n_settings);
    $display("compared %0d element words field by field", sb.n_words);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[i2of5_bar_width_encoder_unit.f]
design/i2of5_pkg.sv
design/i2of5_div.sv
design/i2of5_front.sv
design/i2of5_queue.sv
design/i2of5_back.sv
design/i2of5_bar_width_encoder_unit.sv
verif/i2of5_bar_width_encoder_unit_tb.sv
